@@ sv/fsp_pkg.sv @@
// Shared types and constants for the send-count planner.
// Holds the controller/datapath command and status structs and the quantile table.
// No dependencies.
package fsp_pkg;

   localparam int WANTED_W  = 14;
   localparam int PACKETS_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int QUANT_W   = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_FRAC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_EXP  = 2'd1;

   localparam logic [15:0] LOSS_FRAC_RESET = 16'd6554;
   localparam logic [3:0]  FAIL_EXP_RESET  = 4'd6;

   localparam logic [QUANT_W-1:0] QUANTILE_Q16 [10] = '{
      19'd83988, 19'd152460, 19'd202521, 19'd243729, 19'd279504,
      19'd311520, 19'd340744, 19'd367788, 19'd393072, 19'd416897
   };

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_INIT, ST_EX_CHECK, ST_STEP_BEGIN,
      ST_SW_RD, ST_SW_MUL, ST_SW_WR, ST_FR_CHECK, ST_FR_RD, ST_FR_CMP,
      ST_ANS, ST_TB_RD, ST_TB_OUT, ST_OUT_SAT, ST_AP_SQUARE, ST_AP_MUL,
      ST_AP_ARG, ST_SQ, ST_AP_SECOND, ST_AP_NUM, ST_DV, ST_AP_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic init;
      logic step_begin;
      logic sw_read;
      logic sw_mul;
      logic sw_write;
      logic fr_read;
      logic fr_inc;
      logic ans_update;
      logic tab_read;
      logic out_table;
      logic out_sat;
      logic ap_square;
      logic ap_mul;
      logic ap_arg;
      logic sq_iter;
      logic ap_second;
      logic ap_num;
      logic dv_iter;
      logic ap_out;
   } dp_cmd_type;

   typedef struct packed {
      logic cfg_wr;
      logic exact;
      logic hit;
      logic full;
      logic sweep_last;
      logic front_more;
      logic front_below;
      logic sq_last;
      logic dv_last;
   } dp_status_type;

   function automatic logic [3:0] exp_sel(input logic [3:0] k);
      logic [3:0] r;
      if (k < 4'd1) begin
         r = 4'd0;
      end else if (k > 4'd10) begin
         r = 4'd9;
      end else begin
         r = k - 4'd1;
      end
      return r;
   endfunction

endpackage

@@ sv/fsp_ctrl.sv @@
// Controller state machine of the send-count planner.
// Depends on fsp_pkg; drives fsp_dpath through command and status structs.
module fsp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fsp_pkg::dp_status_type status,
   output fsp_pkg::dp_cmd_type   cmd
);

   fsp_pkg::ctrl_state_type state_ff, state_in;
   logic init_pending_ff, init_pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fsp_pkg::ST_IDLE;
         init_pending_ff <= 1'b1;
      end else begin
         state_ff        <= state_in;
         init_pending_ff <= init_pending_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      init_pending_in = init_pending_ff;
      cmd             = '0;
      if (status.cfg_wr) begin
         init_pending_in = 1'b1;
      end
      case (state_ff)
         fsp_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = fsp_pkg::ST_DISPATCH;
            end
         end
         fsp_pkg::ST_DISPATCH: begin
            if (init_pending_ff) begin
               state_in = fsp_pkg::ST_INIT;
            end else if (status.exact) begin
               state_in = fsp_pkg::ST_EX_CHECK;
            end else begin
               state_in = fsp_pkg::ST_AP_SQUARE;
            end
         end
         fsp_pkg::ST_INIT: begin
            cmd.init        = 1'b1;
            init_pending_in = 1'b0;
            state_in        = fsp_pkg::ST_DISPATCH;
         end
         fsp_pkg::ST_EX_CHECK: begin
            if (status.hit) begin
               state_in = fsp_pkg::ST_TB_RD;
            end else if (status.full) begin
               state_in = fsp_pkg::ST_OUT_SAT;
            end else begin
               state_in = fsp_pkg::ST_STEP_BEGIN;
            end
         end
         fsp_pkg::ST_STEP_BEGIN: begin
            cmd.step_begin = 1'b1;
            state_in       = fsp_pkg::ST_SW_RD;
         end
         fsp_pkg::ST_SW_RD: begin
            cmd.sw_read = 1'b1;
            state_in    = fsp_pkg::ST_SW_MUL;
         end
         fsp_pkg::ST_SW_MUL: begin
            cmd.sw_mul = 1'b1;
            state_in   = fsp_pkg::ST_SW_WR;
         end
         fsp_pkg::ST_SW_WR: begin
            cmd.sw_write = 1'b1;
            state_in = status.sweep_last ? fsp_pkg::ST_FR_CHECK : fsp_pkg::ST_SW_RD;
         end
         fsp_pkg::ST_FR_CHECK: begin
            state_in = status.front_more ? fsp_pkg::ST_FR_RD : fsp_pkg::ST_ANS;
         end
         fsp_pkg::ST_FR_RD: begin
            cmd.fr_read = 1'b1;
            state_in    = fsp_pkg::ST_FR_CMP;
         end
         fsp_pkg::ST_FR_CMP: begin
            if (status.front_below) begin
               cmd.fr_inc = 1'b1;
               state_in   = fsp_pkg::ST_FR_CHECK;
            end else begin
               state_in = fsp_pkg::ST_ANS;
            end
         end
         fsp_pkg::ST_ANS: begin
            cmd.ans_update = 1'b1;
            state_in       = fsp_pkg::ST_EX_CHECK;
         end
         fsp_pkg::ST_TB_RD: begin
            cmd.tab_read = 1'b1;
            state_in     = fsp_pkg::ST_TB_OUT;
         end
         fsp_pkg::ST_TB_OUT: begin
            cmd.out_table = 1'b1;
            state_in      = fsp_pkg::ST_IDLE;
         end
         fsp_pkg::ST_OUT_SAT: begin
            cmd.out_sat = 1'b1;
            state_in    = fsp_pkg::ST_IDLE;
         end
         fsp_pkg::ST_AP_SQUARE: begin
            cmd.ap_square = 1'b1;
            state_in      = fsp_pkg::ST_AP_MUL;
         end
         fsp_pkg::ST_AP_MUL: begin
            cmd.ap_mul = 1'b1;
            state_in   = fsp_pkg::ST_AP_ARG;
         end
         fsp_pkg::ST_AP_ARG: begin
            cmd.ap_arg = 1'b1;
            state_in   = fsp_pkg::ST_SQ;
         end
         fsp_pkg::ST_SQ: begin
            cmd.sq_iter = 1'b1;
            if (status.sq_last) begin
               state_in = fsp_pkg::ST_AP_SECOND;
            end
         end
         fsp_pkg::ST_AP_SECOND: begin
            cmd.ap_second = 1'b1;
            state_in      = fsp_pkg::ST_AP_NUM;
         end
         fsp_pkg::ST_AP_NUM: begin
            cmd.ap_num = 1'b1;
            state_in   = fsp_pkg::ST_DV;
         end
         fsp_pkg::ST_DV: begin
            cmd.dv_iter = 1'b1;
            if (status.dv_last) begin
               state_in = fsp_pkg::ST_AP_OUT;
            end
         end
         fsp_pkg::ST_AP_OUT: begin
            cmd.ap_out = 1'b1;
            state_in   = fsp_pkg::ST_IDLE;
         end
         default: begin
            state_in = fsp_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != fsp_pkg::ST_IDLE);

endmodule

@@ sv/fsp_dpath.sv @@
// Datapath of the send-count planner: registers, distribution and answer memories,
// multipliers, and the shared square-root / divider iteration. Depends on fsp_pkg.
module fsp_dpath #(
   parameter int EXACT_LIMIT = 50,
   parameter int MAX_STEPS   = 1024,
   parameter int PROB_BITS   = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [fsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fsp_pkg::CSR_DAT_W-1:0]       csr_data,
   input  logic [fsp_pkg::WANTED_W-1:0]        req_wanted,
   input  fsp_pkg::dp_cmd_type                 cmd,
   output fsp_pkg::dp_status_type              status,
   output logic                                rsp_valid,
   output logic [fsp_pkg::PACKETS_W-1:0]       rsp_packets,
   output logic                                rsp_saturated
);

   localparam int DEPTH = MAX_STEPS + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(EXACT_LIMIT + 1);
   localparam int TAW   = (EXACT_LIMIT > 1) ? $clog2(EXACT_LIMIT) : 1;
   localparam int PW    = PROB_BITS + 16;
   localparam logic [63:0] UNIT64 = 64'd1 << (PROB_BITS - 1);
   localparam logic [PROB_BITS-1:0] UNIT = PROB_BITS'(UNIT64);
   localparam logic [63:0] THR_TAB [10] = '{
      UNIT64 - (UNIT64 + 64'd5) / 64'd10,
      UNIT64 - (UNIT64 + 64'd50) / 64'd100,
      UNIT64 - (UNIT64 + 64'd500) / 64'd1000,
      UNIT64 - (UNIT64 + 64'd5000) / 64'd10000,
      UNIT64 - (UNIT64 + 64'd50000) / 64'd100000,
      UNIT64 - (UNIT64 + 64'd500000) / 64'd1000000,
      UNIT64 - (UNIT64 + 64'd5000000) / 64'd10000000,
      UNIT64 - (UNIT64 + 64'd50000000) / 64'd100000000,
      UNIT64 - (UNIT64 + 64'd500000000) / 64'd1000000000,
      UNIT64 - (UNIT64 + 64'd5000000000) / 64'd10000000000
   };

   logic [15:0] loss_ff;
   logic [3:0]  fexp_ff;
   logic [fsp_pkg::WANTED_W-1:0] wanted_ff;
   logic [AW-1:0] steps_ff, front_ff, jidx_ff;
   logic [CW-1:0] count_ff;
   logic [PROB_BITS-1:0] dist_mem [DEPTH];
   logic [15:0]          tab_mem [EXACT_LIMIT];
   logic [PROB_BITS-1:0] dist_rd_ff, last_ff, cur_ff, mprev_ff;
   logic [PW-1:0]        prod_ff;
   logic [15:0]          tab_rd_ff;
   logic [37:0] s2_ff;
   logic [63:0] first_ff, ls2_ff, sec_ff, work_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [5:0]  iter_ff;
   logic        rsp_valid_ff, rsp_sat_ff;
   logic [fsp_pkg::PACKETS_W-1:0] rsp_pk_ff;

   logic                 cfg_wr;
   logic [3:0]           sel;
   logic [PROB_BITS-1:0] thr;
   logic [fsp_pkg::QUANT_W-1:0] quant;
   logic [PROB_BITS-1:0] osel, mval, newval;
   logic [AW-1:0]        dist_addr;
   logic                 dist_we;
   logic [PROB_BITS-1:0] dist_wd;
   logic [34:0] sq_rem, sq_trial;
   logic [18:0] dv_rem, dv_den;
   logic [16:0] one_minus;
   logic [33:0] pk_sum;

   assign cfg_wr = csr_valid &&
      (csr_index == fsp_pkg::CSR_LOSS_FRAC || csr_index == fsp_pkg::CSR_FAIL_EXP);
   assign sel   = fsp_pkg::exp_sel(fexp_ff);
   assign thr   = PROB_BITS'(THR_TAB[sel]);
   assign quant = fsp_pkg::QUANTILE_Q16[sel];

   always_comb begin
      if (jidx_ff == steps_ff) begin
         osel = last_ff;
      end else if (jidx_ff == steps_ff + AW'(1)) begin
         osel = '0;
      end else begin
         osel = dist_rd_ff;
      end
   end

   assign mval   = prod_ff[PW-1:16];
   assign newval = cur_ff - mval + mprev_ff;

   always_comb begin
      dist_we   = 1'b0;
      dist_wd   = newval;
      dist_addr = cmd.fr_read ? front_ff : jidx_ff;
      if (cmd.init) begin
         dist_we   = 1'b1;
         dist_wd   = UNIT;
         dist_addr = '0;
      end else if (cmd.sw_write) begin
         dist_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_addr] <= dist_wd;
      end
      if (cmd.sw_read || cmd.fr_read) begin
         dist_rd_ff <= dist_mem[dist_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         tab_mem[0] <= '0;
      end else if (cmd.ans_update && AW'(steps_ff - front_ff) == AW'(count_ff) &&
                   count_ff < CW'(EXACT_LIMIT)) begin
         tab_mem[count_ff[TAW-1:0]] <= 16'(steps_ff);
      end
      if (cmd.tab_read) begin
         tab_rd_ff <= tab_mem[wanted_ff[TAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_ff  <= fsp_pkg::LOSS_FRAC_RESET;
         fexp_ff  <= fsp_pkg::FAIL_EXP_RESET;
         steps_ff <= '0;
         front_ff <= '0;
         count_ff <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.out_table || cmd.out_sat || cmd.ap_out;
         if (cfg_wr) begin
            if (csr_index == fsp_pkg::CSR_LOSS_FRAC) begin
               loss_ff <= csr_data;
            end else begin
               fexp_ff <= csr_data[3:0];
            end
            steps_ff <= '0;
            front_ff <= '0;
            count_ff <= CW'(1);
         end else begin
            if (cmd.step_begin) begin
               steps_ff <= steps_ff + AW'(1);
            end
            if (cmd.fr_inc) begin
               front_ff <= front_ff + AW'(1);
            end
            if (cmd.ans_update && AW'(steps_ff - front_ff) == AW'(count_ff) &&
                count_ff < CW'(EXACT_LIMIT)) begin
               count_ff <= count_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wanted_ff <= req_wanted;
      end
      if (cmd.step_begin) begin
         jidx_ff  <= '0;
         mprev_ff <= '0;
      end
      if (cmd.sw_mul) begin
         cur_ff  <= osel;
         last_ff <= osel;
         prod_ff <= PW'(osel) * PW'(loss_ff);
      end
      if (cmd.sw_write) begin
         mprev_ff <= mval;
         jidx_ff  <= jidx_ff + AW'(1);
      end
   end

   assign sq_rem   = {rem_ff[32:0], work_ff[63:62]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign one_minus = 17'h10000 - 17'(loss_ff);
   assign dv_den   = {1'b0, one_minus, 1'b0};
   assign dv_rem   = {rem_ff[17:0], work_ff[63]};
   assign pk_sum   = 34'(work_ff[63:32]) + 34'(wanted_ff) + 34'd1;

   always_ff @(posedge clock) begin
      if (cmd.ap_square) begin
         s2_ff <= 38'(quant) * 38'(quant);
      end
      if (cmd.ap_mul) begin
         first_ff <= 64'(loss_ff) * 64'({wanted_ff, 33'd0} + 48'(s2_ff));
         ls2_ff   <= 64'(loss_ff) * 64'(s2_ff);
      end
      if (cmd.ap_arg) begin
         work_ff <= 64'(loss_ff) * 64'({wanted_ff, 32'd0} + 47'(ls2_ff[53:18]));
         rem_ff  <= '0;
         root_ff <= '0;
         iter_ff <= '0;
      end
      if (cmd.sq_iter) begin
         work_ff <= {work_ff[61:0], 2'b00};
         iter_ff <= iter_ff + 6'd1;
         if (sq_rem >= sq_trial) begin
            rem_ff  <= sq_rem - sq_trial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= sq_rem;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
      if (cmd.ap_second) begin
         sec_ff <= 64'(51'(quant) * 51'(root_ff)) << 9;
      end
      if (cmd.ap_num) begin
         work_ff <= first_ff + sec_ff;
         rem_ff  <= '0;
         iter_ff <= '0;
      end
      if (cmd.dv_iter) begin
         iter_ff <= iter_ff + 6'd1;
         if (dv_rem >= dv_den) begin
            rem_ff  <= 35'(dv_rem - dv_den);
            work_ff <= {work_ff[62:0], 1'b1};
         end else begin
            rem_ff  <= 35'(dv_rem);
            work_ff <= {work_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_table) begin
         rsp_pk_ff  <= tab_rd_ff;
         rsp_sat_ff <= 1'b0;
      end else if (cmd.out_sat) begin
         rsp_pk_ff  <= '1;
         rsp_sat_ff <= 1'b1;
      end else if (cmd.ap_out) begin
         if (pk_sum > 34'hFFFF) begin
            rsp_pk_ff  <= '1;
            rsp_sat_ff <= 1'b1;
         end else begin
            rsp_pk_ff  <= pk_sum[15:0];
            rsp_sat_ff <= 1'b0;
         end
      end
   end

   assign status.cfg_wr      = cfg_wr;
   assign status.exact       = wanted_ff < fsp_pkg::WANTED_W'(EXACT_LIMIT);
   assign status.hit         = fsp_pkg::WANTED_W'(count_ff) > wanted_ff;
   assign status.full        = steps_ff >= AW'(MAX_STEPS);
   assign status.sweep_last  = (jidx_ff == steps_ff + AW'(1));
   assign status.front_more  = front_ff < steps_ff;
   assign status.front_below = dist_rd_ff < thr;
   assign status.sq_last     = (iter_ff == 6'd31);
   assign status.dv_last     = (iter_ff == 6'd63);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_packets   = rsp_pk_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

@@ sv/fec_send_count_planner_top.sv @@
// Top level of the send-count planner: controller plus datapath.
// Depends on fsp_pkg, fsp_ctrl and fsp_dpath.
//
//   Channel   Ports                                   Handshake
//   request   start, busy, req_wanted                 taken when start & !busy
//   response  rsp_valid, rsp_packets, rsp_saturated  one-cycle strobe, no stall
//   csr       csr_valid, csr_ready, csr_index, csr_data  valid & ready (ready always high)
//
// An item at or above the exact limit runs a square root (32 steps) and then a divide
// (64 steps) before its result strobe. An exact item found in the cache is read from the
// answer table; otherwise each widening step sweeps the used part of the distribution memory
// (steps+2 entries), advances the front past entries below the threshold and may add an
// answer. After reset or a register write the first item first reseeds the cache.
// The response cannot be stalled; busy drops in the cycle the result is shown.
module fec_send_count_planner_top #(
   parameter int EXACT_LIMIT = 50,
   parameter int MAX_STEPS   = 1024,
   parameter int PROB_BITS   = 48
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [fsp_pkg::WANTED_W-1:0]    req_wanted,
   output logic                            rsp_valid,
   output logic [fsp_pkg::PACKETS_W-1:0]   rsp_packets,
   output logic                            rsp_saturated,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fsp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fsp_pkg::CSR_DAT_W-1:0]   csr_data
);

   fsp_pkg::dp_cmd_type    cmd;
   fsp_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   fsp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   fsp_dpath #(
      .EXACT_LIMIT (EXACT_LIMIT),
      .MAX_STEPS   (MAX_STEPS),
      .PROB_BITS   (PROB_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_wanted    (req_wanted),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_packets   (rsp_packets),
      .rsp_saturated (rsp_saturated)
   );

endmodule

@@ test/fec_send_count_planner_top_tb.sv @@
// Testbench for the send-count planner: drives wanted counts and register writes,
// predicts each answer in a behavioral model and checks every response strobe.
// Depends on fsp_pkg and fec_send_count_planner_top.
`timescale 1ns / 100ps

module fec_send_count_planner_top_tb;

   localparam int EXACT_MAX = 50;
   localparam int STEP_MAX  = 1024;
   localparam int FRAC_W    = 47;
   localparam longint unsigned ONE_Q = 64'd1 << FRAC_W;
   localparam logic [fsp_pkg::CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [fsp_pkg::CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;
   localparam int STALL_LIMIT = 8000000;
   localparam int PHASE_IDLE [4] = '{0, 50, 0, 10};

   typedef struct packed {
      logic [fsp_pkg::PACKETS_W-1:0] packets;
      logic                          saturated;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [fsp_pkg::WANTED_W-1:0] req_wanted = '0;
   logic rsp_valid;
   logic [fsp_pkg::PACKETS_W-1:0] rsp_packets;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [fsp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [fsp_pkg::CSR_DAT_W-1:0] csr_data = '0;

   logic [fsp_pkg::WANTED_W-1:0] pending_wanted[$];
   answer_type expected_answers[$];
   int idle_pct = 0;
   int error_count = 0;
   int stall_cycles = 0;

   // Behavioral copy of the planner state.
   logic [15:0] m_loss;
   logic [3:0] m_exp;
   longint unsigned m_dist[STEP_MAX + 2];
   int unsigned m_table[EXACT_MAX];
   int unsigned m_count, m_steps, m_front;

   fec_send_count_planner_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_wanted(req_wanted), .rsp_valid(rsp_valid), .rsp_packets(rsp_packets),
      .rsp_saturated(rsp_saturated), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int unsigned target_sel();
      int unsigned k;
      k = m_exp;
      if (k < 1) k = 1;
      if (k > 10) k = 10;
      return k - 1;
   endfunction

   task automatic clear_plan_cache();
      foreach (m_dist[i]) m_dist[i] = 0;
      foreach (m_table[i]) m_table[i] = 0;
      m_dist[0] = ONE_Q;
      m_count = 1;
      m_steps = 0;
      m_front = 0;
   endtask

   function automatic longint unsigned lost_share(longint unsigned v);
      longint unsigned l;
      l = m_loss;
      return (v >> 16) * l + (((v & 64'hFFFF) * l) >> 16);
   endfunction

   task automatic widen_distribution();
      longint unsigned ten_pow, thr, mv;
      ten_pow = 10;
      for (int i = 0; i < target_sel(); i++) ten_pow = ten_pow * 10;
      thr = ONE_Q - (ONE_Q + ten_pow / 2) / ten_pow;
      m_steps++;
      m_dist[m_steps + 1] = 0;
      m_dist[m_steps] = m_dist[m_steps - 1];
      for (int j = m_steps + 1; j > 0; j--) begin
         mv = lost_share(m_dist[j - 1]);
         m_dist[j] += mv;
         m_dist[j - 1] -= mv;
      end
      while (m_front < m_steps && m_dist[m_front] < thr) m_front++;
      if (m_steps - m_front == m_count && m_count < EXACT_MAX) begin
         m_table[m_count] = m_steps;
         m_count++;
      end
   endtask

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned normal_count(longint unsigned w);
      longint unsigned l, s, s2, first, arg, second, den;
      l = m_loss;
      s = fsp_pkg::QUANTILE_Q16[target_sel()];
      s2 = s * s;
      first = l * ((w << 33) + s2);
      arg = l * ((w << 32) + ((l * s2) >> 18));
      second = (s * int_root(arg)) << 9;
      den = 2 * (65536 - l);
      return (((first + second) / den) >> 32) + w + 1;
   endfunction

   task automatic plan_packets(input logic [fsp_pkg::WANTED_W-1:0] wanted,
                               output answer_type ans);
      longint unsigned pk;
      ans.packets = '1;
      ans.saturated = 1'b1;
      if (wanted < EXACT_MAX) begin
         while (m_count <= wanted) begin
            if (m_steps >= STEP_MAX) return;
            widen_distribution();
         end
         ans.packets = fsp_pkg::PACKETS_W'(m_table[wanted]);
         ans.saturated = 1'b0;
      end else begin
         pk = normal_count(wanted);
         if (pk <= 64'hFFFF) begin
            ans.packets = fsp_pkg::PACKETS_W'(pk);
            ans.saturated = 1'b0;
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Item driver: keeps start high until the item is taken.
   always @(posedge clock) begin
      answer_type ans;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            plan_packets(req_wanted, ans);
            expected_answers = {expected_answers, ans};
         end
         if (pending_wanted.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_wanted <= pending_wanted.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      answer_type exp_ans;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected response packets=%0d", rsp_packets));
         end else begin
            exp_ans = expected_answers.pop_front();
            if (rsp_packets !== exp_ans.packets)
               report_mismatch($sformatf("packets %0d, expected %0d",
                  rsp_packets, exp_ans.packets));
            if (rsp_saturated !== exp_ans.saturated)
               report_mismatch($sformatf("saturated %0b, expected %0b",
                  rsp_saturated, exp_ans.saturated));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(input logic [fsp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fsp_pkg::CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == fsp_pkg::CSR_LOSS_FRAC) begin
         m_loss = val;
         clear_plan_cache();
      end else if (idx == fsp_pkg::CSR_FAIL_EXP) begin
         m_exp = val[3:0];
         clear_plan_cache();
      end
   endtask

   // Polls between edges so that every update of the current edge has settled.
   task automatic wait_drained();
      while (pending_wanted.size() > 0 || start || expected_answers.size() > 0)
         @(negedge clock);
   endtask

   task automatic queue_items(input int n, input bit exact_ok);
      logic [fsp_pkg::WANTED_W-1:0] w;
      for (int i = 0; i < n; i++) begin
         if (exact_ok && $urandom_range(99) < 55)
            w = fsp_pkg::WANTED_W'($urandom_range(EXACT_MAX - 1));
         else if ($urandom_range(1))
            w = fsp_pkg::WANTED_W'($urandom);
         else
            w = fsp_pkg::WANTED_W'($urandom_range(16383, EXACT_MAX));
         pending_wanted = {pending_wanted, w};
      end
   endtask

   initial begin
      m_loss = fsp_pkg::LOSS_FRAC_RESET;
      m_exp = fsp_pkg::FAIL_EXP_RESET;
      clear_plan_cache();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      pending_wanted = '{14'd0, 14'd1, 14'd2, 14'd49, 14'd48, 14'd10, 14'd50, 14'd51,
                         14'd16383, 14'd1000, 14'd5};
      wait_drained();
      write_reg(fsp_pkg::CSR_LOSS_FRAC, 16'd0);
      write_reg(fsp_pkg::CSR_FAIL_EXP, 16'hFFF0);
      pending_wanted = '{14'd0, 14'd5, 14'd49, 14'd50, 14'd16383};
      wait_drained();
      write_reg(fsp_pkg::CSR_LOSS_FRAC, 16'hFFFF);
      write_reg(fsp_pkg::CSR_FAIL_EXP, 16'h000F);
      pending_wanted = '{14'd50, 14'd16383, 14'd100, 14'd1, 14'd2};
      wait_drained();
      write_reg(CSR_UNUSED_A, 16'hFFFF);
      write_reg(CSR_UNUSED_B, 16'h0000);
      pending_wanted = '{14'd3, 14'd8191};
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         idle_pct = PHASE_IDLE[p];
         write_reg(fsp_pkg::CSR_LOSS_FRAC, fsp_pkg::CSR_DAT_W'($urandom_range(20000)));
         write_reg(fsp_pkg::CSR_FAIL_EXP, fsp_pkg::CSR_DAT_W'($urandom));
         queue_items(12, 1'b1);
         wait_drained();
         write_reg(fsp_pkg::CSR_LOSS_FRAC, fsp_pkg::CSR_DAT_W'($urandom));
         write_reg(fsp_pkg::CSR_FAIL_EXP, fsp_pkg::CSR_DAT_W'($urandom_range(10, 1)));
         queue_items(8, 1'b0);
         wait_drained();
      end

      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/fsp_pkg.sv
sv/fsp_ctrl.sv
sv/fsp_dpath.sv
sv/fec_send_count_planner_top.sv
test/fec_send_count_planner_top_tb.sv
